// ----- rtl/core/banker_resource_allocator_core_macros.svh -----
// Assertion macros for the banker resource allocator core.
// Used by banker_resource_allocator_core.sv; expects clk_i and rst_ni in scope.
`ifndef BANKER_RESOURCE_ALLOCATOR_CORE_MACROS_SVH
`define BANKER_RESOURCE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, idle during reset
`define BRA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("banker allocator check failed");

// next-cycle implication, idle during reset
`define BRA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("banker allocator check failed");

`endif

// ----- rtl/core/bra_pkg.sv -----
// Package for the banker resource allocator: command and status codes, defaults.
// No dependencies.
`default_nettype none

package bra_pkg;

  localparam int unsigned DEF_PROCESSES   = 16;
  localparam int unsigned DEF_RESOURCES   = 4;
  localparam int unsigned DEF_AMOUNT_BITS = 8;

  localparam int unsigned FIELD_COUNT      = 4;  // amount ports on the request
  localparam int unsigned AMOUNT_PORT_BITS = 8;
  localparam int unsigned PCOUNT_BITS      = 5;
  localparam int unsigned RCOUNT_BITS      = 3;

  localparam logic [PCOUNT_BITS-1:0] PCOUNT_RESET = 5'd4;
  localparam logic [RCOUNT_BITS-1:0] RCOUNT_RESET = 3'd4;

  // register indexes
  localparam logic REG_PROCESS_COUNT  = 1'b0;
  localparam logic REG_RESOURCE_COUNT = 1'b1;

  typedef enum logic [2:0] {
    CMD_LOAD_ALLOC = 3'd0,
    CMD_LOAD_NEED  = 3'd1,
    CMD_LOAD_AVAIL = 3'd2,
    CMD_REQUEST    = 3'd3,
    CMD_RELEASE    = 3'd4,
    CMD_UNDO       = 3'd5,
    CMD_SAFETY     = 3'd6
  } cmd_e;

  localparam logic [3:0] STS_OK           = 4'd0;
  localparam logic [3:0] STS_BAD_PROCESS  = 4'd1;
  localparam logic [3:0] STS_EXCEEDS_NEED = 4'd2;
  localparam logic [3:0] STS_INSUFFICIENT = 4'd3;
  localparam logic [3:0] STS_OVER_ALLOC   = 4'd4;
  localparam logic [3:0] STS_NOT_DONE     = 4'd5;
  localparam logic [3:0] STS_ALL_RELEASED = 4'd6;
  localparam logic [3:0] STS_NO_UNDO      = 4'd7;
  localparam logic [3:0] STS_SAFE         = 4'd8;
  localparam logic [3:0] STS_UNSAFE       = 4'd9;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EX   = 5'b00010,
    ST_SRD  = 5'b00100,
    ST_SEV  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/core/banker_resource_allocator_core.sv -----
// Banker resource allocator. Load, request, release and undo: row read at the accepting
// edge, execute/write back in the execute state, which waits while the result slot is
// busy; the next request is accepted only after execute returns to idle.
// Safety check: each pass reads and then evaluates each process row in turn (memory read
// + evaluate), up to process_count+1 passes, then one result per cycle while the result slot is free.
// Reset (async, active low) clears control, config and per-row valid bits; unwritten rows
// read as zero, so no clearing pass is needed.
`default_nettype none
`include "banker_resource_allocator_core_macros.svh"

module banker_resource_allocator_core
  import bra_pkg::*;
#(
  parameter int unsigned PROCESSES   = DEF_PROCESSES,
  parameter int unsigned RESOURCES   = DEF_RESOURCES,
  parameter int unsigned AMOUNT_BITS = DEF_AMOUNT_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request channel
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic [2:0]                  command_i,
  input  wire logic [3:0]                  process_id_i,
  input  wire logic [AMOUNT_PORT_BITS-1:0] amount_0_i,
  input  wire logic [AMOUNT_PORT_BITS-1:0] amount_1_i,
  input  wire logic [AMOUNT_PORT_BITS-1:0] amount_2_i,
  input  wire logic [AMOUNT_PORT_BITS-1:0] amount_3_i,
  // result channel
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic [3:0]                  status_o,
  output      logic [3:0]                  sequence_process_o,
  output      logic                        sequence_valid_o,
  output      logic                        last_o,
  // config port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready
);

  localparam int unsigned PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int unsigned CW = $clog2(PROCESSES + 1);
  localparam int unsigned AB = AMOUNT_BITS;
  localparam int unsigned RW = RESOURCES * AMOUNT_BITS;

  typedef logic [AB-1:0] amt_t;

  function automatic amt_t sat_add(amt_t a, amt_t b);
    logic [AB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AB] ? '1 : s[AB-1:0];
  endfunction

  function automatic amt_t sat_sub(amt_t a, amt_t b);
    return (a > b) ? amt_t'(a - b) : '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Config registers (APB, zero wait states)
  // ---------------------------------------------------------------------------
  logic [PCOUNT_BITS-1:0] pcnt_q;
  logic [RCOUNT_BITS-1:0] rcnt_q;
  logic                   cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= PCOUNT_RESET;
      rcnt_q <= RCOUNT_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_PROCESS_COUNT) begin
        pcnt_q <= pwdata[PCOUNT_BITS-1:0];
      end else begin
        rcnt_q <= pwdata[RCOUNT_BITS-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PROCESS_COUNT) begin
      prdata[PCOUNT_BITS-1:0] = pcnt_q;
    end else begin
      prdata[RCOUNT_BITS-1:0] = rcnt_q;
    end
  end

  // counts clamped to the built size; masks of the rows and lanes in use
  logic [PCOUNT_BITS-1:0] np;
  logic [RCOUNT_BITS-1:0] nr;
  logic [PROCESSES-1:0]   proc_use;
  logic [RESOURCES-1:0]   res_use;

  always_comb begin
    np = (pcnt_q > PCOUNT_BITS'(PROCESSES)) ? PCOUNT_BITS'(PROCESSES) : pcnt_q;
    nr = (rcnt_q > RCOUNT_BITS'(RESOURCES)) ? RCOUNT_BITS'(RESOURCES) : rcnt_q;
    for (int p = 0; p < PROCESSES; p++) proc_use[p] = PCOUNT_BITS'(p) < np;
    for (int r = 0; r < RESOURCES; r++) res_use[r] = RCOUNT_BITS'(r) < nr;
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e               state_q;
  logic [2:0]           cmd_q;
  logic [3:0]           pid_q;
  logic                 pid_ok_q;
  amt_t                 amt_q [RESOURCES];
  amt_t                 avail_q [RESOURCES];
  logic [PROCESSES-1:0] fin_q;
  amt_t                 lga_q [RESOURCES];     // last grant amounts
  logic [PW-1:0]        lgp_q;                 // last grant process
  logic                 undo_q;
  // safety scan
  amt_t                 work_q [RESOURCES];
  logic [PROCESSES-1:0] trial_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        emit_idx_q;
  logic [PW-1:0]        scan_p_q;
  logic                 progress_q;
  logic [PW-1:0]        seq_q [PROCESSES];
  // result register
  logic                 out_valid_q;
  logic [3:0]           status_q;
  logic [3:0]           seqp_q;
  logic                 seqv_q;
  logic                 last_q;

  logic [AMOUNT_PORT_BITS-1:0] amt_in [FIELD_COUNT];
  assign amt_in[0] = amount_0_i;
  assign amt_in[1] = amount_1_i;
  assign amt_in[2] = amount_2_i;
  assign amt_in[3] = amount_3_i;

  logic in_acc, out_free;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  logic [PW-1:0] pid_idx;
  assign pid_idx = PW'(pid_q);

  // ---------------------------------------------------------------------------
  // Row memories: need and allocation, one row per process, registered read.
  // Per-row valid bits give the all-zero reset without a clearing pass.
  // ---------------------------------------------------------------------------
  logic [RW-1:0]        need_mem  [PROCESSES];
  logic [RW-1:0]        alloc_mem [PROCESSES];
  logic [RW-1:0]        rd_need_q, rd_alloc_q;
  logic                 rd_vld_q;
  logic [PROCESSES-1:0] row_vld_q;
  logic [PW-1:0]        rd_addr, wr_addr;
  logic                 mem_we;
  logic [RW-1:0]        need_wd, alloc_wd;

  // execute keeps its row on the read port while the result slot is busy
  always_comb begin
    rd_addr = scan_p_q;
    if (state_q == ST_IDLE) begin
      rd_addr = (command_i == CMD_UNDO) ? lgp_q : PW'(process_id_i);
    end else if (state_q == ST_EX) begin
      rd_addr = wr_addr;
    end
  end

  assign wr_addr = (cmd_q == CMD_UNDO) ? lgp_q : pid_idx;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      need_mem[wr_addr]  <= need_wd;
      alloc_mem[wr_addr] <= alloc_wd;
    end
    rd_need_q  <= need_mem[rd_addr];
    rd_alloc_q <= alloc_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) row_vld_q[wr_addr] <= 1'b1;
      rd_vld_q <= (32'(rd_addr) < PROCESSES) ? row_vld_q[rd_addr] : 1'b0;
    end
  end

  amt_t need_row [RESOURCES];
  amt_t alloc_row [RESOURCES];
  always_comb begin
    for (int r = 0; r < RESOURCES; r++) begin
      need_row[r]  = rd_vld_q ? rd_need_q[r*AB +: AB]  : '0;
      alloc_row[r] = rd_vld_q ? rd_alloc_q[r*AB +: AB] : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute step for the single-result commands
  // ---------------------------------------------------------------------------
  logic                 exceeds, insuff, over_alloc, need_nz, all_done;
  logic [PROCESSES-1:0] fin_after;
  logic [3:0]           ex_status;
  logic                 ex_grant, ex_undo_clr, ex_fin_set;
  amt_t                 need_n [RESOURCES];
  amt_t                 alloc_n [RESOURCES];
  amt_t                 avail_n [RESOURCES];

  always_comb begin
    exceeds    = 1'b0;
    insuff     = 1'b0;
    over_alloc = 1'b0;
    need_nz    = 1'b0;
    for (int r = 0; r < RESOURCES; r++) begin
      if (res_use[r]) begin
        exceeds    = exceeds    | (amt_q[r] > need_row[r]);
        insuff     = insuff     | (amt_q[r] > avail_q[r]);
        over_alloc = over_alloc | (amt_q[r] > alloc_row[r]);
        need_nz    = need_nz    | (need_row[r] != '0);
      end
    end
    fin_after = fin_q | (PROCESSES'(1) << pid_idx);
    all_done  = &(fin_after | ~proc_use);
  end

  always_comb begin
    ex_status   = STS_OK;
    mem_we      = 1'b0;
    ex_grant    = 1'b0;
    ex_undo_clr = 1'b0;
    ex_fin_set  = 1'b0;
    for (int r = 0; r < RESOURCES; r++) begin
      need_n[r]  = need_row[r];
      alloc_n[r] = alloc_row[r];
      avail_n[r] = avail_q[r];
    end
    case (cmd_q)
      CMD_LOAD_ALLOC, CMD_LOAD_NEED: begin
        if (!pid_ok_q) begin
          ex_status = STS_BAD_PROCESS;
        end else begin
          mem_we      = 1'b1;
          ex_undo_clr = 1'b1;
          for (int r = 0; r < RESOURCES; r++) begin
            if (res_use[r]) begin
              if (cmd_q == CMD_LOAD_ALLOC) alloc_n[r] = amt_q[r];
              else need_n[r] = amt_q[r];
            end
          end
        end
      end
      CMD_LOAD_AVAIL: begin
        ex_undo_clr = 1'b1;
        for (int r = 0; r < RESOURCES; r++) begin
          if (res_use[r]) avail_n[r] = amt_q[r];
        end
      end
      CMD_REQUEST: begin
        if (!pid_ok_q || fin_q[pid_idx]) begin
          ex_status = STS_BAD_PROCESS;
        end else if (exceeds) begin
          ex_status = STS_EXCEEDS_NEED;
        end else if (insuff) begin
          ex_status = STS_INSUFFICIENT;
        end else begin
          mem_we   = 1'b1;
          ex_grant = 1'b1;
          for (int r = 0; r < RESOURCES; r++) begin
            if (res_use[r]) begin
              alloc_n[r] = sat_add(alloc_row[r], amt_q[r]);
              need_n[r]  = sat_sub(need_row[r], amt_q[r]);
              avail_n[r] = sat_sub(avail_q[r], amt_q[r]);
            end
          end
        end
      end
      CMD_RELEASE: begin
        if (!pid_ok_q) begin
          ex_status = STS_BAD_PROCESS;
        end else if (over_alloc) begin
          ex_status = STS_OVER_ALLOC;
        end else if (need_nz) begin
          ex_status = STS_NOT_DONE;
        end else begin
          mem_we      = 1'b1;
          ex_undo_clr = 1'b1;
          ex_fin_set  = 1'b1;
          ex_status   = all_done ? STS_ALL_RELEASED : STS_OK;
          for (int r = 0; r < RESOURCES; r++) begin
            if (res_use[r]) begin
              avail_n[r] = sat_add(avail_q[r], amt_q[r]);
              alloc_n[r] = '0;
            end
          end
        end
      end
      CMD_UNDO: begin
        if (!undo_q) begin
          ex_status = STS_NO_UNDO;
        end else begin
          mem_we      = 1'b1;
          ex_undo_clr = 1'b1;
          for (int r = 0; r < RESOURCES; r++) begin
            if (res_use[r]) begin
              alloc_n[r] = sat_sub(alloc_row[r], lga_q[r]);
              need_n[r]  = sat_add(need_row[r], lga_q[r]);
              avail_n[r] = sat_add(avail_q[r], lga_q[r]);
            end
          end
        end
      end
      default: ;
    endcase
    // only the execute step writes, and only when the result slot is free
    mem_we = mem_we & (state_q == ST_EX) & out_free;
  end

  always_comb begin
    for (int r = 0; r < RESOURCES; r++) begin
      need_wd[r*AB +: AB]  = need_n[r];
      alloc_wd[r*AB +: AB] = alloc_n[r];
    end
  end

  // ---------------------------------------------------------------------------
  // Safety scan: each row is read, then evaluated; passes repeat while any row is granted
  // ---------------------------------------------------------------------------
  logic fits, fit_now, scan_last, all_trial, emit_final;
  amt_t work_n [RESOURCES];

  always_comb begin
    fits = 1'b1;
    for (int r = 0; r < RESOURCES; r++) begin
      if (res_use[r] && (need_row[r] > work_q[r])) fits = 1'b0;
      work_n[r] = res_use[r] ? sat_add(work_q[r], alloc_row[r]) : work_q[r];
    end
    fit_now    = ~trial_q[scan_p_q] & fits;
    scan_last  = (scan_p_q == PW'(np - PCOUNT_BITS'(1)));
    all_trial  = &(trial_q | ~proc_use);
    emit_final = ~all_trial | (count_q == '0) | (emit_idx_q == CW'(count_q - CW'(1)));
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fin_q      <= '0;
      undo_q     <= 1'b0;
      lgp_q      <= '0;
      trial_q    <= '0;
      count_q    <= '0;
      emit_idx_q <= '0;
      scan_p_q   <= '0;
      progress_q <= 1'b0;
      cmd_q      <= '0;
      pid_q      <= '0;
      pid_ok_q   <= 1'b0;
      for (int r = 0; r < RESOURCES; r++) begin
        amt_q[r]   <= '0;
        avail_q[r] <= '0;
        lga_q[r]   <= '0;
        work_q[r]  <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_q    <= command_i;
            pid_q    <= process_id_i;
            pid_ok_q <= PCOUNT_BITS'(process_id_i) < np;
            for (int r = 0; r < RESOURCES; r++) amt_q[r] <= AB'(amt_in[r]);
            if (command_i == CMD_SAFETY) begin
              for (int r = 0; r < RESOURCES; r++) work_q[r] <= avail_q[r];
              trial_q    <= fin_q;
              count_q    <= '0;
              emit_idx_q <= '0;
              scan_p_q   <= '0;
              progress_q <= 1'b0;
              state_q    <= (np == '0) ? ST_EMIT : ST_SRD;
            end else if ((command_i == CMD_LOAD_ALLOC) || (command_i == CMD_LOAD_NEED) ||
                         (command_i == CMD_LOAD_AVAIL) || (command_i == CMD_REQUEST) ||
                         (command_i == CMD_RELEASE) || (command_i == CMD_UNDO)) begin
              state_q <= ST_EX;
            end
          end
        end
        ST_EX: begin
          if (out_free) begin
            for (int r = 0; r < RESOURCES; r++) avail_q[r] <= avail_n[r];
            if (ex_fin_set) fin_q <= fin_after;
            if (ex_undo_clr) undo_q <= 1'b0;
            if (ex_grant) begin
              undo_q <= 1'b1;
              lgp_q  <= pid_idx;
              for (int r = 0; r < RESOURCES; r++) lga_q[r] <= res_use[r] ? amt_q[r] : '0;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_SRD: begin
          state_q <= ST_SEV;
        end
        ST_SEV: begin
          if (fit_now) begin
            trial_q[scan_p_q] <= 1'b1;
            count_q <= CW'(count_q + CW'(1));
            for (int r = 0; r < RESOURCES; r++) work_q[r] <= work_n[r];
          end
          if (scan_last) begin
            if (progress_q || fit_now) begin
              scan_p_q   <= '0;
              progress_q <= 1'b0;
              state_q    <= ST_SRD;
            end else begin
              state_q <= ST_EMIT;
            end
          end else begin
            scan_p_q   <= PW'(scan_p_q + PW'(1));
            progress_q <= progress_q | fit_now;
            state_q    <= ST_SRD;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            emit_idx_q <= CW'(emit_idx_q + CW'(1));
            if (emit_final) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // sequence buffer, written in grant order during the scan
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SEV) && fit_now) seq_q[count_q[PW-1:0]] <= scan_p_q;
  end

  // ---------------------------------------------------------------------------
  // Result register: decouples the sequencer from result backpressure
  // ---------------------------------------------------------------------------
  logic produce;
  assign produce = out_free & ((state_q == ST_EX) | (state_q == ST_EMIT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (produce) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      if (state_q == ST_EX) begin
        status_q <= ex_status;
        seqp_q   <= '0;
        seqv_q   <= 1'b0;
        last_q   <= 1'b1;
      end else if (!all_trial) begin
        status_q <= STS_UNSAFE;
        seqp_q   <= '0;
        seqv_q   <= 1'b0;
        last_q   <= 1'b1;
      end else if (count_q == '0) begin
        status_q <= STS_SAFE;
        seqp_q   <= '0;
        seqv_q   <= 1'b0;
        last_q   <= 1'b1;
      end else begin
        status_q <= STS_SAFE;
        seqp_q   <= 4'(seq_q[emit_idx_q[PW-1:0]]);
        seqv_q   <= 1'b1;
        last_q   <= emit_final;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign sequence_process_o = seqp_q;
  assign sequence_valid_o   = seqv_q;
  assign last_o             = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BRA_ASSERT_IMP(a_scan_row_in_use, state_q == ST_SEV, PCOUNT_BITS'(scan_p_q) < np)
  `BRA_ASSERT_IMP(a_count_bounded, state_q == ST_EMIT, PCOUNT_BITS'(count_q) <= np)
  `BRA_ASSERT_NXT(a_grant_arms_undo, (state_q == ST_EX) && out_free && ex_grant, undo_q)
  `BRA_ASSERT_NXT(a_unsafe_single, (state_q == ST_EMIT) && out_free && !all_trial,
                  out_valid_o && last_o && (status_o == STS_UNSAFE) && (state_q == ST_IDLE))

endmodule

`default_nettype wire
